[hdl/lfgs_pkg.sv]
// Shared constants, types and register codes for the follow-gap steering block.
package lfgs_pkg;
	localparam int MAX_RAYS_DEF = 2048;
	localparam int NUM_REGS = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_RANGE   = 3'd0,
		REG_OBST_THR    = 3'd1,
		REG_BUBBLE_SCL  = 3'd2,
		REG_ANGLE_STEP  = 3'd3,
		REG_MIN_GAP     = 3'd4,
		REG_TOP_SPEED   = 3'd5,
		REG_START_IDX   = 3'd6,
		REG_END_IDX     = 3'd7
	} reg_idx_t;

	localparam logic [14:0] SPEED_MID = 15'd3000;
	localparam logic [14:0] SPEED_LOW = 15'd2000;
	localparam logic [27:0] ANG_STRAIGHT = 28'd80000;
	localparam logic [27:0] ANG_WIDE = 28'd349000;

	typedef struct packed {
		logic [15:0] max_range;
		logic [15:0] obst_thr;
		logic [23:0] bubble_scale;
		logic [15:0] angle_step;
		logic [10:0] min_gap;
		logic [14:0] top_speed;
		logic [10:0] start_idx;
		logic [10:0] end_idx;
	} cfg_t;
endpackage

[hdl/lfgs_if.sv]
// Valid/ready channel interfaces for samples, results and configuration.
interface lfgs_in_if;
	logic valid;
	logic ready;
	logic [15:0] range_mm;
	logic last_sample;
	modport source (output valid, range_mm, last_sample, input ready);
	modport sink (input valid, range_mm, last_sample, output ready);
endinterface

interface lfgs_out_if;
	logic valid;
	logic ready;
	logic signed [27:0] steering_urad;
	logic [14:0] speed_mm_s;
	logic gap_found;
	logic [10:0] target_index;
	modport source (output valid, steering_urad, speed_mm_s, gap_found, target_index,
		input ready);
	modport sink (input valid, steering_urad, speed_mm_s, gap_found, target_index,
		output ready);
endinterface

interface lfgs_cfg_if;
	logic valid;
	logic ready;
	logic [lfgs_pkg::CFG_IDX_W-1:0] index;
	logic [lfgs_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/lidar_follow_gap_steering.sv]
// Follow-the-gap steering top level: window store, bubble and gap sequencer.
//
//  channel | dir | payload
//  smp     | in  | range_mm[15:0], last_sample
//  res     | out | steering_urad[27:0], speed_mm_s[14:0], gap_found, target_index[10:0]
//  cfg     | in  | index[2:0], data[23:0]
//
// Samples are stored when inside the window. A last sample, once the window
// is full, runs a bubble pass (one read per entry, a divider run per close nonzero
// entry and one write per inflated entry), then a gap pass with one read per entry,
// then a multiply and output.
// Reset clears control and registers; the range store holds no reset. The result
// register holds until taken; no new sample is taken meanwhile.
module lidar_follow_gap_steering #(
	parameter int MAX_RAYS = lfgs_pkg::MAX_RAYS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	lfgs_in_if.sink  smp,
	lfgs_out_if.source res,
	lfgs_cfg_if.sink cfg
);
	localparam int AW = $clog2(MAX_RAYS);
	localparam int LW = AW + 1;

	typedef enum logic [3:0] {
		S_LOAD, S_B_RD, S_B_CHK, S_B_DIV, S_B_BACK, S_B_FWD,
		S_G_RD, S_G_CHK, S_MUL, S_OUT
	} state_t;

	lfgs_pkg::cfg_t regs;
	lfgs_cfg u_cfg (.clk(clk), .arst_n(arst_n), .cfg(cfg), .regs(regs));

	logic [15:0] mem [MAX_RAYS];
	logic [15:0] rd_q;
	logic        we;
	logic [AW-1:0] wa, ra;
	logic [15:0] wd;

	state_t state_q;
	logic [11:0] pos_q, wcnt_q;
	logic [LW-1:0] len_q, i_q, n_q, k_q, t_q;
	logic [LW-1:0] rb_q, span_q, mid_q;
	logic in_obs_q, found_q;
	logic div_start, div_done;
	logic [23:0] quo;
	logic signed [27:0] steer_q;

	lfgs_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(regs.bubble_scale),
		.divisor(rd_q), .done(div_done), .quotient(quo));

	logic [11:0] rel;
	logic in_win;
	logic [11:0] len_raw;
	logic [LW-1:0] len_c, centre;
	logic [15:0] clip;
	assign rel = pos_q - {1'b0, regs.start_idx};
	assign in_win = (pos_q >= {1'b0, regs.start_idx}) && (pos_q <= {1'b0, regs.end_idx})
		&& ({1'b0, rel} < 13'(MAX_RAYS));
	assign len_raw = {1'b0, regs.end_idx} - {1'b0, regs.start_idx} + 12'd1;
	assign len_c = (regs.end_idx < regs.start_idx) ? '0 :
		(32'(len_raw) > MAX_RAYS) ? LW'(MAX_RAYS) : LW'(len_raw);
	assign centre = len_q >> 1;
	assign clip = (smp.range_mm < regs.max_range) ? smp.range_mm : regs.max_range;

	// span candidate for gap pass
	logic [LW-1:0] last_i, cspan;
	logic rd_obs;
	assign rd_obs = rd_q <= regs.obst_thr;
	assign last_i = rd_obs ? i_q - LW'(1) : i_q;
	assign cspan = last_i - rb_q;

	// resume point after a bubble, clamped to the window end
	logic [LW:0] i_next;
	logic [LW-1:0] i_resume;
	assign i_next = {1'b0, i_q} + {1'b0, n_q} + (LW+1)'(1);
	assign i_resume = (i_next >= {1'b0, len_q}) ? len_q : i_next[LW-1:0];

	assign smp.ready = (state_q == S_LOAD);
	assign div_start = (state_q == S_B_CHK) && (rd_q < regs.obst_thr) && (rd_q != 16'd0);

	logic [23:0] nsat;
	assign nsat = (quo > 24'(len_q)) ? 24'(len_q) : quo;

	always_comb begin
		we = 1'b0; wa = '0; wd = regs.obst_thr;
		unique case (state_q)
			S_LOAD: begin
				we = smp.valid && in_win;
				wa = rel[AW-1:0];
				wd = clip;
			end
			S_B_BACK: begin
				we = (k_q < n_q) && (t_q != '0);
				wa = t_q[AW-1:0];
			end
			S_B_FWD: begin
				we = k_q < n_q;
				wa = AW'(i_q + k_q);
			end
			default: ;
		endcase
	end
	assign ra = i_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			pos_q <= '0; wcnt_q <= '0; len_q <= '0; i_q <= '0; n_q <= '0;
			k_q <= '0; t_q <= '0; rb_q <= '0; span_q <= '0; mid_q <= '0;
			in_obs_q <= 1'b0; found_q <= 1'b0; steer_q <= '0;
			res.valid <= 1'b0;
			res.steering_urad <= '0; res.speed_mm_s <= '0;
			res.gap_found <= 1'b0; res.target_index <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: if (smp.valid) begin
					if (smp.last_sample) begin
						pos_q <= '0;
						wcnt_q <= '0;
						len_q <= len_c;
						i_q <= '0;
						found_q <= 1'b0;
						if (len_c != '0 && ({1'b0, (in_win && wcnt_q != 12'd4095) ?
							wcnt_q + 12'd1 : wcnt_q} >= 13'(len_c)))
							state_q <= S_B_RD;
						else
							state_q <= S_MUL;
					end else begin
						if (in_win && wcnt_q != 12'd4095) wcnt_q <= wcnt_q + 12'd1;
						if (pos_q != 12'd4095) pos_q <= pos_q + 12'd1;
					end
				end
				S_B_RD: begin
					if (i_q >= len_q) begin
						i_q <= '0; rb_q <= '0; in_obs_q <= 1'b0; span_q <= '0;
						state_q <= S_G_RD;
					end else state_q <= S_B_CHK;
				end
				S_B_CHK: begin
					if (rd_q < regs.obst_thr) begin
						if (rd_q == 16'd0) begin
							n_q <= len_q; k_q <= '0; t_q <= i_q; state_q <= S_B_BACK;
						end else state_q <= S_B_DIV;
					end else begin
						i_q <= i_q + LW'(1); state_q <= S_B_RD;
					end
				end
				S_B_DIV: if (div_done) begin
					n_q <= LW'(nsat); k_q <= '0; t_q <= i_q; state_q <= S_B_BACK;
				end
				S_B_BACK: begin
					if (k_q < n_q && t_q != '0) begin
						k_q <= k_q + LW'(1); t_q <= t_q - LW'(1);
					end else begin
						k_q <= '0;
						if ({1'b0, len_q} > {1'b0, i_q} + {1'b0, n_q}) state_q <= S_B_FWD;
						else begin
							i_q <= i_resume; state_q <= S_B_RD;
						end
					end
				end
				S_B_FWD: begin
					if (k_q < n_q) k_q <= k_q + LW'(1);
					else begin
						i_q <= i_resume; state_q <= S_B_RD;
					end
				end
				S_G_RD: begin
					if (i_q >= len_q) state_q <= S_MUL;
					else state_q <= S_G_CHK;
				end
				S_G_CHK: begin
					if (rd_obs && !in_obs_q) begin
						in_obs_q <= 1'b1;
						if (i_q > rb_q && cspan > LW'(regs.min_gap) && cspan > span_q) begin
							span_q <= cspan;
							mid_q <= LW'(({1'b0, rb_q} + {1'b0, last_i}) >> 1);
							found_q <= 1'b1;
						end
					end else if (in_obs_q && !rd_obs) begin
						rb_q <= i_q; in_obs_q <= 1'b0;
					end else if (!in_obs_q && i_q == len_q - LW'(1)) begin
						if (cspan > LW'(regs.min_gap) && cspan > span_q) begin
							span_q <= cspan;
							mid_q <= LW'(({1'b0, rb_q} + {1'b0, last_i}) >> 1);
							found_q <= 1'b1;
						end
					end
					i_q <= i_q + LW'(1);
					state_q <= S_G_RD;
				end
				S_MUL: begin
					steer_q <= found_q ? 28'($signed({1'b0, mid_q}) - $signed({1'b0, centre}))
						* $signed({12'd0, regs.angle_step}) : '0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res.valid) begin
						res.valid <= 1'b1;
						res.steering_urad <= steer_q;
						res.gap_found <= found_q;
						res.target_index <= 11'(found_q ? mid_q : centre);
						if (!found_q) res.speed_mm_s <= '0;
						else if ((steer_q < 0 ? 28'(-steer_q) : 28'(steer_q))
							< lfgs_pkg::ANG_STRAIGHT) res.speed_mm_s <= regs.top_speed;
						else if ((steer_q < 0 ? 28'(-steer_q) : 28'(steer_q))
							< lfgs_pkg::ANG_WIDE) res.speed_mm_s <= lfgs_pkg::SPEED_MID;
						else res.speed_mm_s <= lfgs_pkg::SPEED_LOW;
					end else if (res.ready) begin
						res.valid <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		smp.ready |-> !res.valid) else $error("ready while result pending");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.steering_urad))
		else $error("result dropped");
	ap_nogap: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.gap_found |-> res.speed_mm_s == '0 && res.steering_urad == '0)
		else $error("no-gap result not zero");
endmodule

[hdl/lfgs_div.sv]
// Radix-2 restoring divider, 24-bit dividend by 16-bit divisor, one bit per cycle.
module lfgs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [23:0] quotient
);
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [16:0] rem_q;
	logic [23:0] quo_q;
	logic [15:0] dsr_q;
	logic [16:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q[15:0], quo_q[23]};
	assign diff = {1'b0, trial} - {2'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd23) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				rem_q <= diff[16:0];
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

[hdl/lfgs_cfg.sv]
// Configuration register file.
module lfgs_cfg (
	input  logic          clk,
	input  logic          arst_n,
	lfgs_cfg_if.sink      cfg,
	output lfgs_pkg::cfg_t regs
);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.max_range <= 16'd10000;
			regs.obst_thr <= 16'd500;
			regs.bubble_scale <= 24'd68760;
			regs.angle_step <= 16'd4363;
			regs.min_gap <= 11'd10;
			regs.top_speed <= 15'd5000;
			regs.start_idx <= 11'd180;
			regs.end_idx <= 11'd900;
		end else if (cfg.valid) begin
			unique case (lfgs_pkg::reg_idx_t'(cfg.index))
				lfgs_pkg::REG_MAX_RANGE:  regs.max_range <= cfg.data[15:0];
				lfgs_pkg::REG_OBST_THR:   regs.obst_thr <= cfg.data[15:0];
				lfgs_pkg::REG_BUBBLE_SCL: regs.bubble_scale <= cfg.data[23:0];
				lfgs_pkg::REG_ANGLE_STEP: regs.angle_step <= cfg.data[15:0];
				lfgs_pkg::REG_MIN_GAP:    regs.min_gap <= cfg.data[10:0];
				lfgs_pkg::REG_TOP_SPEED:  regs.top_speed <= cfg.data[14:0];
				lfgs_pkg::REG_START_IDX:  regs.start_idx <= cfg.data[10:0];
				lfgs_pkg::REG_END_IDX:    regs.end_idx <= cfg.data[10:0];
				default: ;
			endcase
		end
	end
endmodule
